[design/dstwr_pkg.sv]
package dstwr_pkg;

   localparam int STAMP_BITS            = 40;
   localparam int TOF_BITS              = 32;
   localparam int INTERVAL_BITS_DEFAULT = 32;

   // Quotient bits kept by the divider: enough to tell 2^31 apart from larger.
   localparam int QUOT_BITS = TOF_BITS + 1;

   // Register stages inside the numerator pipeline.
   localparam int NUM_STAGES = 4;

   localparam logic [QUOT_BITS-1:0] POS_LIMIT = {2'b00, {(TOF_BITS-1){1'b1}}};
   localparam logic [QUOT_BITS-1:0] NEG_LIMIT = {2'b01, {(TOF_BITS-1){1'b0}}};

   localparam logic signed [TOF_BITS-1:0] TOF_MAX = {1'b0, {(TOF_BITS-1){1'b1}}};
   localparam logic signed [TOF_BITS-1:0] TOF_MIN = {1'b1, {(TOF_BITS-1){1'b0}}};

endpackage

[design/dstwr_if.sv]
interface dstwr_req_if;
   logic                                valid;
   logic                                ready;
   logic [dstwr_pkg::STAMP_BITS-1:0]    poll_sent_time;
   logic [dstwr_pkg::STAMP_BITS-1:0]    response_recv_time;
   logic [dstwr_pkg::STAMP_BITS-1:0]    final_sent_time;
   logic [dstwr_pkg::STAMP_BITS-1:0]    poll_recv_time;
   logic [dstwr_pkg::STAMP_BITS-1:0]    response_sent_time;
   logic [dstwr_pkg::STAMP_BITS-1:0]    final_recv_time;

   modport source (
      output valid, poll_sent_time, response_recv_time, final_sent_time,
             poll_recv_time, response_sent_time, final_recv_time,
      input  ready
   );

   modport sink (
      input  valid, poll_sent_time, response_recv_time, final_sent_time,
             poll_recv_time, response_sent_time, final_recv_time,
      output ready
   );
endinterface

interface dstwr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [dstwr_pkg::TOF_BITS-1:0] time_of_flight;
   logic                                 zero_divisor;

   modport source (
      output valid, time_of_flight, zero_divisor,
      input  ready
   );

   modport sink (
      input  valid, time_of_flight, zero_divisor,
      output ready
   );
endinterface

[design/ds_twr_time_of_flight.sv]
// Double-sided two-way ranging time of flight. Each item carries the six
// 40-bit radio timestamps of one exchange; only the low INTERVAL_BITS bits of
// each are used. The block forms the two round and two reply intervals modulo
// 2^INTERVAL_BITS and returns (round1*round2 - reply1*reply2) divided by the
// sum of all four intervals, exact and truncated toward zero, saturated to
// 32 bits signed. An all-zero interval sum returns 0 with zero_divisor set.
// One item enters per cycle unless back-pressure fills the pipeline; every item
// gives exactly one result. An item passes 40 register stages: one interval
// stage, four numerator stages (split multiply, product combine, difference,
// magnitude), 34 divider stages (range check plus one quotient bit per stage)
// and the output register. Empty stages collapse under back-pressure, so the
// block keeps accepting items while a finished result waits to be taken,
// until every stage holds an item.
module ds_twr_time_of_flight #(
   parameter int INTERVAL_BITS = dstwr_pkg::INTERVAL_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   dstwr_req_if.sink      req_bus,
   dstwr_rsp_if.source    rsp_bus
);

   localparam int W  = INTERVAL_BITS;
   localparam int SW = W + 2;
   localparam int QB = dstwr_pkg::QUOT_BITS;
   localparam int TB = dstwr_pkg::TOF_BITS;

   // interval stage
   logic          s1_valid_ff;
   logic          s1_en;
   logic [W-1:0]  round1_ff, round2_ff, reply1_ff, reply2_ff;
   logic [W-1:0]  round1_in, round2_in, reply1_in, reply2_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          zero_ff;

   // numerator pipeline outputs
   logic          num_in_ready;
   logic          num_valid;
   logic [2*W-1:0] num_mag;
   logic          num_neg;
   logic [SW-1:0] num_sum;
   logic          num_zero;

   // divider outputs
   logic          div_in_ready;
   logic          div_valid;
   logic [QB-1:0] div_quot;
   logic          div_ovf;
   logic          div_neg;
   logic          div_zero;

   // output register
   logic                 out_en;
   logic                 rsp_valid_ff;
   logic signed [TB-1:0] tof_ff, tof_in;
   logic                 zflag_ff;

   // Intervals wrap modulo 2^W: a later stamp below an earlier one is fine.
   assign round1_in = req_bus.response_recv_time[W-1:0] - req_bus.poll_sent_time[W-1:0];
   assign reply1_in = req_bus.response_sent_time[W-1:0] - req_bus.poll_recv_time[W-1:0];
   assign round2_in = req_bus.final_recv_time[W-1:0] - req_bus.response_sent_time[W-1:0];
   assign reply2_in = req_bus.final_sent_time[W-1:0] - req_bus.response_recv_time[W-1:0];
   assign sum_in    = SW'(round1_in) + SW'(round2_in) + SW'(reply1_in) + SW'(reply2_in);

   // Take a new item whenever the interval stage is empty or drains forward.
   assign s1_en         = !s1_valid_ff || num_in_ready;
   assign req_bus.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         round1_ff <= round1_in;
         round2_ff <= round2_in;
         reply1_ff <= reply1_in;
         reply2_ff <= reply2_in;
         sum_ff    <= sum_in;
         zero_ff   <= sum_in == '0;
      end
   end

   dstwr_num #(
      .W (W)
   ) u_num (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (num_in_ready),
      .round1    (round1_ff),
      .round2    (round2_ff),
      .reply1    (reply1_ff),
      .reply2    (reply2_ff),
      .in_sum    (sum_ff),
      .in_zero   (zero_ff),
      .out_valid (num_valid),
      .out_ready (div_in_ready),
      .mag       (num_mag),
      .neg       (num_neg),
      .out_sum   (num_sum),
      .out_zero  (num_zero)
   );

   dstwr_div #(
      .W (W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (div_in_ready),
      .mag       (num_mag),
      .in_neg    (num_neg),
      .sum       (num_sum),
      .in_zero   (num_zero),
      .out_valid (div_valid),
      .out_ready (out_en),
      .quot      (div_quot),
      .ovf       (div_ovf),
      .out_neg   (div_neg),
      .out_zero  (div_zero)
   );

   // Saturate the magnitude, apply the sign, force zero on an empty divisor.
   always_comb begin
      priority if (div_zero) begin
         tof_in = '0;
      end else if (!div_neg) begin
         tof_in = (div_ovf || div_quot > dstwr_pkg::POS_LIMIT) ?
                  dstwr_pkg::TOF_MAX : $signed(div_quot[TB-1:0]);
      end else begin
         tof_in = (div_ovf || div_quot > dstwr_pkg::NEG_LIMIT) ?
                  dstwr_pkg::TOF_MIN : $signed(~div_quot[TB-1:0] + TB'(1));
      end
   end

   // Load the output register when it is empty or its item is taken.
   assign out_en = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         tof_ff   <= tof_in;
         zflag_ff <= div_zero;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.time_of_flight = tof_ff;
   assign rsp_bus.zero_divisor   = zflag_ff;

endmodule

[design/dstwr_num.sv]
// Numerator pipeline: split products, combine, difference, magnitude and sign.
module dstwr_num #(
   parameter int W = dstwr_pkg::INTERVAL_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [W-1:0]      round1,
   input  logic [W-1:0]      round2,
   input  logic [W-1:0]      reply1,
   input  logic [W-1:0]      reply2,
   input  logic [W+1:0]      in_sum,
   input  logic              in_zero,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2*W-1:0]    mag,
   output logic              neg,
   output logic [W+1:0]      out_sum,
   output logic              out_zero
);

   localparam int NS = dstwr_pkg::NUM_STAGES;
   localparam int H  = (W + 1) / 2;
   localparam int G  = W - H;
   localparam int PW = 2 * W;

   logic          valid_ff [NS];
   logic          en       [NS];
   logic [W+1:0]  sum_ff   [NS];
   logic          zero_ff  [NS];

   // stage 0: partial products
   logic [2*H-1:0] pa00_ff, pb00_ff;
   logic [H+G-1:0] pa01_ff, pa10_ff, pb01_ff, pb10_ff;
   logic [2*G-1:0] pa11_ff, pb11_ff;
   logic [2*H-1:0] pa00_in, pb00_in;
   logic [H+G-1:0] pa01_in, pa10_in, pb01_in, pb10_in;
   logic [2*G-1:0] pa11_in, pb11_in;

   // stage 1: full products
   logic [PW-1:0]  prod_a_ff, prod_b_ff, prod_a_in, prod_b_in;

   // stage 2: signed difference
   logic [PW:0]    diff_ff, diff_in;

   // stage 3: magnitude
   logic [PW-1:0]  mag_ff, mag_in;
   logic           neg_ff;

   // advance a stage when it is empty or its successor advances
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      pa00_in = (2*H)'(round1[H-1:0]) * (2*H)'(round2[H-1:0]);
      pa01_in = (H+G)'(round1[H-1:0]) * (H+G)'(round2[W-1:H]);
      pa10_in = (H+G)'(round1[W-1:H]) * (H+G)'(round2[H-1:0]);
      pa11_in = (2*G)'(round1[W-1:H]) * (2*G)'(round2[W-1:H]);
      pb00_in = (2*H)'(reply1[H-1:0]) * (2*H)'(reply2[H-1:0]);
      pb01_in = (H+G)'(reply1[H-1:0]) * (H+G)'(reply2[W-1:H]);
      pb10_in = (H+G)'(reply1[W-1:H]) * (H+G)'(reply2[H-1:0]);
      pb11_in = (2*G)'(reply1[W-1:H]) * (2*G)'(reply2[W-1:H]);

      prod_a_in = PW'(pa00_ff) + (PW'(pa01_ff) << H) + (PW'(pa10_ff) << H)
                + (PW'(pa11_ff) << (2 * H));
      prod_b_in = PW'(pb00_ff) + (PW'(pb01_ff) << H) + (PW'(pb10_ff) << H)
                + (PW'(pb11_ff) << (2 * H));

      diff_in = {1'b0, prod_a_ff} - {1'b0, prod_b_ff};

      mag_in = diff_ff[PW] ? (~diff_ff[PW-1:0] + PW'(1)) : diff_ff[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pa00_ff    <= pa00_in;
         pa01_ff    <= pa01_in;
         pa10_ff    <= pa10_in;
         pa11_ff    <= pa11_in;
         pb00_ff    <= pb00_in;
         pb01_ff    <= pb01_in;
         pb10_ff    <= pb10_in;
         pb11_ff    <= pb11_in;
         sum_ff[0]  <= in_sum;
         zero_ff[0] <= in_zero;
      end
      if (en[1]) begin
         prod_a_ff  <= prod_a_in;
         prod_b_ff  <= prod_b_in;
         sum_ff[1]  <= sum_ff[0];
         zero_ff[1] <= zero_ff[0];
      end
      if (en[2]) begin
         diff_ff    <= diff_in;
         sum_ff[2]  <= sum_ff[1];
         zero_ff[2] <= zero_ff[1];
      end
      if (en[3]) begin
         mag_ff     <= mag_in;
         neg_ff     <= diff_ff[PW];
         sum_ff[3]  <= sum_ff[2];
         zero_ff[3] <= zero_ff[2];
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign mag       = mag_ff;
   assign neg       = neg_ff;
   assign out_sum   = sum_ff[NS-1];
   assign out_zero  = zero_ff[NS-1];

endmodule

[design/dstwr_div.sv]
// Pipelined restoring divider: range check, then one quotient bit per stage.
module dstwr_div #(
   parameter int W = dstwr_pkg::INTERVAL_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [2*W-1:0]                  mag,
   input  logic                            in_neg,
   input  logic [W+1:0]                    sum,
   input  logic                            in_zero,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [dstwr_pkg::QUOT_BITS-1:0] quot,
   output logic                            ovf,
   output logic                            out_neg,
   output logic                            out_zero
);

   localparam int QB = dstwr_pkg::QUOT_BITS;
   localparam int NS = QB + 1;
   localparam int PW = 2 * W;
   localparam int SW = W + 2;

   logic          valid_ff [NS];
   logic          en       [NS];
   logic [SW-1:0] rem_ff   [NS];
   logic [QB-1:0] rq_ff    [NS];
   logic [SW-1:0] sum_ff   [NS];
   logic          ovf_ff   [NS];
   logic          neg_ff   [NS];
   logic          zero_ff  [NS];

   logic [PW+QB-1:0] ext;
   logic [PW-1:0]    hi;
   logic             ovf_in;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   // quotient reaches 2^QB exactly when the dividend's upper part reaches the divisor
   assign ext    = {{QB{1'b0}}, mag};
   assign hi     = ext[PW+QB-1:QB];
   assign ovf_in = hi >= PW'(sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= hi[SW-1:0];
         rq_ff[0]   <= ext[QB-1:0];
         sum_ff[0]  <= sum;
         ovf_ff[0]  <= ovf_in;
         neg_ff[0]  <= in_neg;
         zero_ff[0] <= in_zero;
      end
   end

   for (genvar k = 1; k < NS; k++) begin : g_step
      logic [SW:0] r2;
      logic [SW:0] r2_sub;
      logic        ge;

      // shift in the next dividend bit, subtract when it fits
      assign r2     = {rem_ff[k-1], rq_ff[k-1][QB-1]};
      assign r2_sub = r2 - {1'b0, sum_ff[k-1]};
      assign ge     = r2 >= {1'b0, sum_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= ge ? r2_sub[SW-1:0] : r2[SW-1:0];
            rq_ff[k]   <= {rq_ff[k-1][QB-2:0], ge};
            sum_ff[k]  <= sum_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign quot      = rq_ff[NS-1];
   assign ovf       = ovf_ff[NS-1];
   assign out_neg   = neg_ff[NS-1];
   assign out_zero  = zero_ff[NS-1];

endmodule

[design/dstwr_checker.sv]
module dstwr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [dstwr_pkg::TOF_BITS-1:0] rsp_time_of_flight,
   input logic                                  rsp_zero_divisor
);

   // a taken output slot frees the whole pipeline for a new item
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output side is ready");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_divisor) |-> (rsp_time_of_flight == '0))
      else $error("nonzero time of flight with zero divisor");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_time_of_flight)
                                     && $stable(rsp_zero_divisor)))
      else $error("stalled result changed");

endmodule

bind ds_twr_time_of_flight dstwr_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_time_of_flight (rsp_bus.time_of_flight),
   .rsp_zero_divisor   (rsp_bus.zero_divisor)
);

[sim/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Interval width the block is built with; the predictor follows it.
   localparam int IVL = dstwr_pkg::INTERVAL_BITS_DEFAULT;

   // Random items per idling phase; three phases give about 1500 items.
   localparam int PHASE_ITEMS = 500;

   // Room after the last owed result for a stray result to pass the pipeline.
   localparam int DRAIN_CYCLES = 80;

   // Hard stop, far beyond the slowest legal run.
   localparam int CYCLE_LIMIT = 400000;

   typedef logic [dstwr_pkg::STAMP_BITS-1:0] stamp_type;

   localparam stamp_type IVL_MAX = stamp_type'((64'd1 << IVL) - 64'd1);

   // The six timestamps of one ranging exchange, as they enter the block.
   typedef struct packed {
      stamp_type poll_sent;
      stamp_type response_recv;
      stamp_type final_sent;
      stamp_type poll_recv;
      stamp_type response_sent;
      stamp_type final_recv;
   } exchange_type;

   // One result item: flight time and the zero-divisor flag.
   typedef struct packed {
      logic signed [dstwr_pkg::TOF_BITS-1:0] tof;
      logic                                  zero;
   } flight_type;

   // Directed row: stamps, plus a hand-typed answer where one is obvious.
   typedef struct packed {
      exchange_type                          stamps;
      logic                                  typed;
      logic signed [dstwr_pkg::TOF_BITS-1:0] want_tof;
      logic                                  want_zero;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 16;

   // Column order: poll_sent, response_recv, final_sent,
   //               poll_recv, response_sent, final_recv, typed, tof, zero.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // All stamps zero: every interval is zero, so the divisor is zero.
      '{'{40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000},
        1'b1, 32'sd0, 1'b1},
      // All stamps at their maximum: again no interval at all.
      '{'{40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
          40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF},
        1'b1, 32'sd0, 1'b1},
      // Stamps differ only above the interval width: the upper bits drop out.
      '{'{40'hAB_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000},
        1'b1, 32'sd0, 1'b1},
      // Both round intervals at maximum, replies zero: largest positive result.
      '{'{40'h00_0000_0000, 40'h00_FFFF_FFFF, 40'h00_FFFF_FFFF,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_FFFF_FFFF},
        1'b1, 32'sd2147483647, 1'b0},
      // Both reply intervals at maximum, rounds zero: largest negative result.
      '{'{40'h00_0000_0000, 40'h00_0000_0000, 40'h00_FFFF_FFFF,
          40'h00_0000_0000, 40'h00_FFFF_FFFF, 40'h00_FFFF_FFFF},
        1'b1, -32'sd2147483647, 1'b0},
      // Rounds of 10, no reply time: 100 / 20.
      '{'{40'h00_0000_0000, 40'h00_0000_000A, 40'h00_0000_000A,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_000A},
        1'b1, 32'sd5, 1'b0},
      // Replies of 3, no round time: -9 / 6 truncates toward zero.
      '{'{40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0003,
          40'h00_0000_0000, 40'h00_0000_0003, 40'h00_0000_0003},
        1'b1, -32'sd1, 1'b0},
      // Rounds of 3: 9 / 6 truncates down.
      '{'{40'h00_0000_0000, 40'h00_0000_0003, 40'h00_0000_0003,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0003},
        1'b1, 32'sd1, 1'b0},
      // Only the first round is nonzero: zero numerator, nonzero divisor.
      '{'{40'h00_0000_0000, 40'h00_0000_0005, 40'h00_0000_0005,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000},
        1'b1, 32'sd0, 1'b0},
      // Only the second round, at maximum.
      '{'{40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0000,
          40'h00_0000_0000, 40'h00_0000_0000, 40'h00_FFFF_FFFF},
        1'b1, 32'sd0, 1'b0},
      // Reply of max and 1 over a divisor of 2^32: just above -1, so zero.
      '{'{40'h00_0000_0000, 40'h00_0000_0000, 40'h00_0000_0001,
          40'h00_0000_0000, 40'h00_FFFF_FFFF, 40'h00_FFFF_FFFF},
        1'b1, 32'sd0, 1'b0},
      // Later stamps below earlier ones in their low 32 bits, on both sides.
      '{'{40'h00_FFFF_FFF0, 40'h01_0000_0010, 40'h01_0000_1010,
          40'hFF_FFFF_FF00, 40'h00_0000_0F00, 40'h00_0000_1F40},
        1'b0, 32'sd0, 1'b0},
      // Alternating bit patterns.
      '{'{40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
          40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555},
        1'b0, 32'sd0, 1'b0},
      // A plausible exchange; the flight time comes to 1456 ticks.
      '{'{40'h10_0000_0000, 40'h10_0001_2345, 40'h10_0002_0000,
          40'h3C_1234_0000, 40'h3C_1235_1F00, 40'h3C_1236_0CC0},
        1'b0, 32'sd0, 1'b0},
      // Fast tag reply, slow anchor reply.
      '{'{40'h7F_FFFF_F000, 40'h80_0007_1000, 40'h80_0007_2000,
          40'h00_0100_0000, 40'h00_0106_F000, 40'h00_0106_F3A0},
        1'b0, 32'sd0, 1'b0},
      // Stamps straddling the top of the 40-bit range.
      '{'{40'hFF_FFFF_FFF8, 40'h00_0000_4000, 40'h00_0001_0000,
          40'hFF_FFFF_8000, 40'h00_0000_B000, 40'h00_0001_7000},
        1'b0, 32'sd0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   dstwr_req_if req_bus ();
   dstwr_rsp_if rsp_bus ();

   ds_twr_time_of_flight #(
      .INTERVAL_BITS (IVL)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Results still owed by the block, oldest first.
   flight_type pending_flights [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int sender_idle_pct;
   int receiver_idle_pct;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Exact time of flight for one exchange: wide products, signed
   // difference, truncating division, saturation to the output width.
   function automatic flight_type flight_time_of(input exchange_type x);
      logic [IVL-1:0]   round1;
      logic [IVL-1:0]   reply1;
      logic [IVL-1:0]   round2;
      logic [IVL-1:0]   reply2;
      logic [IVL+1:0]   span;
      logic [2*IVL-1:0] prod_round;
      logic [2*IVL-1:0] prod_reply;
      logic [2*IVL-1:0] magnitude;
      logic [2*IVL-1:0] quotient;
      logic             negative;
      flight_type       r;
      round1 = IVL'(x.response_recv - x.poll_sent);
      reply1 = IVL'(x.response_sent - x.poll_recv);
      round2 = IVL'(x.final_recv - x.response_sent);
      reply2 = IVL'(x.final_sent - x.response_recv);
      span = (IVL+2)'(round1) + (IVL+2)'(round2) + (IVL+2)'(reply1) + (IVL+2)'(reply2);
      r.tof  = '0;
      r.zero = 1'b0;
      if (span == '0) begin
         r.zero = 1'b1;
         return r;
      end
      prod_round = (2*IVL)'(round1) * (2*IVL)'(round2);
      prod_reply = (2*IVL)'(reply1) * (2*IVL)'(reply2);
      negative   = prod_reply > prod_round;
      magnitude  = negative ? prod_reply - prod_round : prod_round - prod_reply;
      quotient   = magnitude / (2*IVL)'(span);
      if (!negative) begin
         r.tof = (quotient > dstwr_pkg::POS_LIMIT) ? dstwr_pkg::TOF_MAX :
                 quotient[dstwr_pkg::TOF_BITS-1:0];
      end else begin
         r.tof = (quotient > dstwr_pkg::NEG_LIMIT) ? dstwr_pkg::TOF_MIN :
                 -quotient[dstwr_pkg::TOF_BITS-1:0];
      end
      return r;
   endfunction

   function automatic stamp_type random_stamp();
      return {8'($urandom_range(0, 255)), 32'($urandom)};
   endfunction

   // Lay out the six stamps from the tag and anchor clock bases and four intervals.
   function automatic exchange_type stamps_from(input stamp_type tag_base,
                                                input stamp_type anchor_base,
                                                input stamp_type round1,
                                                input stamp_type reply1,
                                                input stamp_type round2,
                                                input stamp_type reply2);
      exchange_type x;
      x.poll_sent     = tag_base;
      x.response_recv = tag_base + round1;
      x.final_sent    = x.response_recv + reply2;
      x.poll_recv     = anchor_base;
      x.response_sent = anchor_base + reply1;
      x.final_recv    = x.response_sent + round2;
      return x;
   endfunction

   function automatic stamp_type corner_interval();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return stamp_type'(1);
         2:       return IVL_MAX - stamp_type'(1);
         3:       return IVL_MAX;
         default: return random_stamp() & IVL_MAX;
      endcase
   endfunction

   // Mostly well-formed exchanges with random content; the rest is noise,
   // tiny intervals, empty exchanges and interval corners.
   function automatic exchange_type random_exchange();
      int           pick;
      stamp_type    flight;
      stamp_type    reply1;
      stamp_type    reply2;
      exchange_type x;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         flight = stamp_type'($urandom_range(0, 3000));
         reply1 = stamp_type'($urandom_range(100, 32'h3FFF_FFFF));
         reply2 = stamp_type'($urandom_range(100, 32'h3FFF_FFFF));
         x = stamps_from(random_stamp(), random_stamp(),
                         stamp_type'(2) * flight + reply1
                            + stamp_type'($urandom_range(0, 63)),
                         reply1,
                         stamp_type'(2) * flight + reply2
                            + stamp_type'($urandom_range(0, 63)),
                         reply2);
      end else if (pick < 75) begin
         x = {random_stamp(), random_stamp(), random_stamp(),
              random_stamp(), random_stamp(), random_stamp()};
      end else if (pick < 88) begin
         x = stamps_from(random_stamp(), random_stamp(),
                         stamp_type'($urandom_range(0, 7)), stamp_type'($urandom_range(0, 7)),
                         stamp_type'($urandom_range(0, 7)), stamp_type'($urandom_range(0, 7)));
      end else if (pick < 91) begin
         x = stamps_from(random_stamp(), random_stamp(), '0, '0, '0, '0);
      end else begin
         x = stamps_from(random_stamp(), random_stamp(), corner_interval(),
                         corner_interval(), corner_interval(), corner_interval());
      end
      return x;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Offer one exchange, idling first at the sender's rate, and hold it
   // until the block takes it. Returns at the accepting edge.
   task automatic send_exchange(input exchange_type x, input flight_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.poll_sent_time     <= x.poll_sent;
      req_bus.response_recv_time <= x.response_recv;
      req_bus.final_sent_time    <= x.final_sent;
      req_bus.poll_recv_time     <= x.poll_recv;
      req_bus.response_sent_time <= x.response_sent;
      req_bus.final_recv_time    <= x.final_recv;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // The block took the item at this edge; its result is still in the pipeline.
      pending_flights.push_back(want);
   endtask

   // Receiver: stall at the current rate and check every result item taken.
   always @(posedge clock) begin
      flight_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_flights.size() == 0) begin
               report_mismatch("result item with no exchange pending");
            end else begin
               want = pending_flights.pop_front();
               if (rsp_bus.time_of_flight !== want.tof)
                  report_mismatch($sformatf("time_of_flight %0d, predicted %0d",
                                            rsp_bus.time_of_flight, want.tof));
               if (rsp_bus.zero_divisor !== want.zero)
                  report_mismatch($sformatf("zero_divisor %0b, predicted %0b",
                                            rsp_bus.zero_divisor, want.zero));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      flight_type want;
      // Drive reset and every request input to a known value before the first edge.
      reset                      <= 1'b1;
      req_bus.valid              <= 1'b0;
      req_bus.poll_sent_time     <= '0;
      req_bus.response_recv_time <= '0;
      req_bus.final_sent_time    <= '0;
      req_bus.poll_recv_time     <= '0;
      req_bus.response_sent_time <= '0;
      req_bus.final_recv_time    <= '0;
      sender_idle_pct   = 29;
      receiver_idle_pct = 69;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: take the typed answer where there is one, else predict.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].typed) begin
            want.tof  = DIRECTED[i].want_tof;
            want.zero = DIRECTED[i].want_zero;
         end else begin
            want = flight_time_of(DIRECTED[i].stamps);
         end
         send_exchange(DIRECTED[i].stamps, want);
      end

      // Random exchanges in three idling phases: slow receiver, slow
      // sender, then both at full rate.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 29;
               receiver_idle_pct = 69;
            end
            1: begin
               sender_idle_pct   = 69;
               receiver_idle_pct = 29;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            exchange_type x;
            x = random_exchange();
            send_exchange(x, flight_time_of(x));
         end
      end

      // Drop valid, wait out every owed result, then give stray results time to show.
      req_bus.valid <= 1'b0;
      while (pending_flights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
